### hw/rtl/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types, character codes, token types and scan modes for the
// expression token scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int FIELD_W = 16;
    localparam int TYPE_W  = 5;
    localparam int ERR_W   = 2;
    localparam int MODE_W  = 4;
    localparam int MAX_RES = 3;
    localparam int CNT_W   = 2;

    // scan modes
    localparam logic [MODE_W-1:0] M_IDLE     = 4'd0;
    localparam logic [MODE_W-1:0] M_IDENT    = 4'd1;
    localparam logic [MODE_W-1:0] M_NUM_INT  = 4'd2;
    localparam logic [MODE_W-1:0] M_NUM_FRAC = 4'd3;
    localparam logic [MODE_W-1:0] M_STRING   = 4'd4;
    localparam logic [MODE_W-1:0] M_BANG     = 4'd5;
    localparam logic [MODE_W-1:0] M_BANG_EQ  = 4'd6;
    localparam logic [MODE_W-1:0] M_EQ       = 4'd7;
    localparam logic [MODE_W-1:0] M_EQ_EQ    = 4'd8;
    localparam logic [MODE_W-1:0] M_BAR      = 4'd9;
    localparam logic [MODE_W-1:0] M_AMP      = 4'd10;
    localparam logic [MODE_W-1:0] M_LT       = 4'd11;
    localparam logic [MODE_W-1:0] M_GT       = 4'd12;
    localparam logic [MODE_W-1:0] M_DOLLAR   = 4'd13;

    // token types
    localparam logic [TYPE_W-1:0] TT_END      = 5'd0;
    localparam logic [TYPE_W-1:0] TT_IDENT    = 5'd1;
    localparam logic [TYPE_W-1:0] TT_NUMBER   = 5'd2;
    localparam logic [TYPE_W-1:0] TT_STRING   = 5'd3;
    localparam logic [TYPE_W-1:0] TT_LBRACK   = 5'd4;
    localparam logic [TYPE_W-1:0] TT_RBRACK   = 5'd5;
    localparam logic [TYPE_W-1:0] TT_LBRACE   = 5'd6;
    localparam logic [TYPE_W-1:0] TT_RBRACE   = 5'd7;
    localparam logic [TYPE_W-1:0] TT_LPAREN   = 5'd8;
    localparam logic [TYPE_W-1:0] TT_RPAREN   = 5'd9;
    localparam logic [TYPE_W-1:0] TT_TEMPLATE = 5'd10;
    localparam logic [TYPE_W-1:0] TT_PLUS     = 5'd11;
    localparam logic [TYPE_W-1:0] TT_MINUS    = 5'd12;
    localparam logic [TYPE_W-1:0] TT_STAR     = 5'd13;
    localparam logic [TYPE_W-1:0] TT_NOT      = 5'd14;
    localparam logic [TYPE_W-1:0] TT_OR       = 5'd15;
    localparam logic [TYPE_W-1:0] TT_AND      = 5'd16;
    localparam logic [TYPE_W-1:0] TT_EQ       = 5'd17;
    localparam logic [TYPE_W-1:0] TT_NE       = 5'd18;
    localparam logic [TYPE_W-1:0] TT_GT       = 5'd19;
    localparam logic [TYPE_W-1:0] TT_LT       = 5'd20;
    localparam logic [TYPE_W-1:0] TT_GE       = 5'd21;
    localparam logic [TYPE_W-1:0] TT_LE       = 5'd22;
    localparam logic [TYPE_W-1:0] TT_DIV      = 5'd23;
    localparam logic [TYPE_W-1:0] TT_MOD      = 5'd24;
    localparam logic [TYPE_W-1:0] TT_MATCH    = 5'd25;
    localparam logic [TYPE_W-1:0] TT_NMATCH   = 5'd26;
    localparam logic [TYPE_W-1:0] TT_QUEST    = 5'd27;
    localparam logic [TYPE_W-1:0] TT_COLON    = 5'd28;
    localparam logic [TYPE_W-1:0] TT_DOT      = 5'd29;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OPEN_STR   = 2'd2;

    // characters
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    typedef struct packed {
        logic [TYPE_W-1:0]  token_type;
        logic [FIELD_W-1:0] start_position;
        logic [FIELD_W-1:0] token_length;
        logic [ERR_W-1:0]   error_code;
        logic               end_of_text;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]           count;
        result_t [MAX_RES-1:0]      items;
    } bundle_t;

    function automatic result_t make_result(
        input logic [TYPE_W-1:0]  ty,
        input logic [FIELD_W-1:0] start,
        input logic [FIELD_W-1:0] len,
        input logic [ERR_W-1:0]   err,
        input logic               eot
    );
        result_t r;
        r.token_type     = ty;
        r.start_position = start;
        r.token_length   = len;
        r.error_code     = err;
        r.end_of_text    = eot;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_DOLLAR) || (c == CH_UNDER);
    endfunction

    // single-character token type, TT_END when the byte is not one
    function automatic logic [TYPE_W-1:0] single_type(input logic [7:0] c);
        logic [TYPE_W-1:0] t;
        case (c)
            CH_LBRACK: t = TT_LBRACK;
            CH_RBRACK: t = TT_RBRACK;
            CH_LBRACE: t = TT_LBRACE;
            CH_RBRACE: t = TT_RBRACE;
            CH_LPAREN: t = TT_LPAREN;
            CH_RPAREN: t = TT_RPAREN;
            CH_PLUS:   t = TT_PLUS;
            CH_MINUS:  t = TT_MINUS;
            CH_STAR:   t = TT_STAR;
            CH_SLASH:  t = TT_DIV;
            CH_PCT:    t = TT_MOD;
            CH_QUEST:  t = TT_QUEST;
            CH_COLON:  t = TT_COLON;
            CH_DOT:    t = TT_DOT;
            default:   t = TT_END;
        endcase
        return t;
    endfunction

endpackage

### hw/rtl/ets_scan.sv
// ----------------------------------------------------------------------------
// ets_scan
// Scanner state registers and the per-byte next-state and result logic.
// Produces a bundle of up to three result words for each byte.
// ----------------------------------------------------------------------------
module ets_scan #(
    parameter int POSITION_BITS = ets_pkg::POSITION_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       char_code,
    input  logic             last_of_text,
    output ets_pkg::bundle_t bundle
);

    localparam int P = POSITION_BITS;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};
    localparam logic [P-1:0] LEN_ONE = P'(1);
    localparam logic [P-1:0] LEN_TWO = P'(2);

    logic [ets_pkg::MODE_W-1:0] mode_reg,  mode_next;
    logic [7:0]                 quote_reg, quote_next;
    logic [P-1:0]               start_reg, start_next;
    logic [P-1:0]               len_reg,   len_next;
    logic [P-1:0]               pos_reg,   pos_next;
    logic                       err_reg,   err_next;

    function automatic logic [P-1:0] sat_inc(input logic [P-1:0] x);
        return (x == POS_MAX) ? x : x + LEN_ONE;
    endfunction

    always_comb
    begin
        logic [ets_pkg::CNT_W-1:0] cnt;
        logic                      used;
        logic [ets_pkg::TYPE_W-1:0] st;
        ets_pkg::bundle_t          b;

        mode_next  = mode_reg;
        quote_next = quote_reg;
        start_next = start_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        pos_next   = pos_reg + LEN_ONE;
        cnt        = '0;
        used       = 1'b0;
        b          = '0;
        st         = ets_pkg::single_type(char_code);

        if (!err_reg)
        begin
            if (mode_next != ets_pkg::M_IDLE)
            begin
                if (mode_next == ets_pkg::M_DOLLAR)
                begin
                    if (char_code == ets_pkg::CH_LBRACE)
                    begin
                        b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_TEMPLATE,
                            16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                        cnt = cnt + 1'b1;
                        mode_next = ets_pkg::M_IDLE;
                    end
                    else
                    begin
                        mode_next = ets_pkg::M_IDENT;
                    end
                end
                case (mode_next)
                    ets_pkg::M_IDENT:
                    begin
                        if (ets_pkg::is_ident(char_code))
                        begin
                            len_next = sat_inc(len_next);
                            used = 1'b1;
                        end
                        else
                        begin
                            b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_IDENT,
                                16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                            cnt = cnt + 1'b1;
                            mode_next = ets_pkg::M_IDLE;
                        end
                    end
                    ets_pkg::M_NUM_INT, ets_pkg::M_NUM_FRAC:
                    begin
                        if (ets_pkg::is_digit(char_code))
                        begin
                            len_next = sat_inc(len_next);
                            used = 1'b1;
                        end
                        else if (char_code == ets_pkg::CH_DOT)
                        begin
                            used = 1'b1;
                            if (mode_next == ets_pkg::M_NUM_FRAC)
                            begin
                                b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_END,
                                    16'(start_next), 16'(len_next),
                                    ets_pkg::ERR_UNEXPECTED, 1'b0);
                                cnt = cnt + 1'b1;
                                mode_next = ets_pkg::M_IDLE;
                                err_next = 1'b1;
                            end
                            else
                            begin
                                mode_next = ets_pkg::M_NUM_FRAC;
                                len_next = sat_inc(len_next);
                            end
                        end
                        else
                        begin
                            b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_NUMBER,
                                16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                            cnt = cnt + 1'b1;
                            mode_next = ets_pkg::M_IDLE;
                        end
                    end
                    ets_pkg::M_STRING:
                    begin
                        len_next = sat_inc(len_next);
                        used = 1'b1;
                        if (char_code == quote_next)
                        begin
                            b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_STRING,
                                16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                            cnt = cnt + 1'b1;
                            mode_next = ets_pkg::M_IDLE;
                        end
                    end
                    ets_pkg::M_BANG:
                    begin
                        if (char_code == ets_pkg::CH_TILDE)
                        begin
                            len_next = sat_inc(len_next);
                            used = 1'b1;
                            b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_NMATCH,
                                16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                            cnt = cnt + 1'b1;
                            mode_next = ets_pkg::M_IDLE;
                        end
                        else if (char_code == ets_pkg::CH_EQ)
                        begin
                            len_next = sat_inc(len_next);
                            used = 1'b1;
                            mode_next = ets_pkg::M_BANG_EQ;
                        end
                        else
                        begin
                            b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_NOT,
                                16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                            cnt = cnt + 1'b1;
                            mode_next = ets_pkg::M_IDLE;
                        end
                    end
                    ets_pkg::M_BANG_EQ, ets_pkg::M_EQ_EQ:
                    begin
                        if (char_code == ets_pkg::CH_EQ)
                        begin
                            len_next = sat_inc(len_next);
                            used = 1'b1;
                        end
                        b.items[cnt] = ets_pkg::make_result(
                            (mode_next == ets_pkg::M_BANG_EQ) ? ets_pkg::TT_NE : ets_pkg::TT_EQ,
                            16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                        cnt = cnt + 1'b1;
                        mode_next = ets_pkg::M_IDLE;
                    end
                    ets_pkg::M_EQ:
                    begin
                        used = 1'b1;
                        if (char_code == ets_pkg::CH_TILDE)
                        begin
                            len_next = sat_inc(len_next);
                            b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_MATCH,
                                16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                            cnt = cnt + 1'b1;
                            mode_next = ets_pkg::M_IDLE;
                        end
                        else if (char_code == ets_pkg::CH_EQ)
                        begin
                            len_next = sat_inc(len_next);
                            mode_next = ets_pkg::M_EQ_EQ;
                        end
                        else
                        begin
                            b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_END,
                                16'(start_next), 16'(LEN_TWO), ets_pkg::ERR_UNEXPECTED, 1'b0);
                            cnt = cnt + 1'b1;
                            mode_next = ets_pkg::M_IDLE;
                            err_next = 1'b1;
                        end
                    end
                    ets_pkg::M_BAR, ets_pkg::M_AMP:
                    begin
                        used = 1'b1;
                        if ((mode_next == ets_pkg::M_BAR && char_code == ets_pkg::CH_BAR) ||
                            (mode_next == ets_pkg::M_AMP && char_code == ets_pkg::CH_AMP))
                        begin
                            len_next = sat_inc(len_next);
                            b.items[cnt] = ets_pkg::make_result(
                                (mode_next == ets_pkg::M_BAR) ? ets_pkg::TT_OR : ets_pkg::TT_AND,
                                16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                        end
                        else
                        begin
                            b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_END,
                                16'(start_next), 16'(LEN_TWO), ets_pkg::ERR_UNEXPECTED, 1'b0);
                            err_next = 1'b1;
                        end
                        cnt = cnt + 1'b1;
                        mode_next = ets_pkg::M_IDLE;
                    end
                    ets_pkg::M_LT, ets_pkg::M_GT:
                    begin
                        if (char_code == ets_pkg::CH_EQ)
                        begin
                            len_next = sat_inc(len_next);
                            used = 1'b1;
                            b.items[cnt] = ets_pkg::make_result(
                                (mode_next == ets_pkg::M_LT) ? ets_pkg::TT_LE : ets_pkg::TT_GE,
                                16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                        end
                        else
                        begin
                            b.items[cnt] = ets_pkg::make_result(
                                (mode_next == ets_pkg::M_LT) ? ets_pkg::TT_LT : ets_pkg::TT_GT,
                                16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                        end
                        cnt = cnt + 1'b1;
                        mode_next = ets_pkg::M_IDLE;
                    end
                    default:
                    begin
                        mode_next = ets_pkg::M_IDLE;
                    end
                endcase
            end

            if (!used && !err_next)
            begin
                start_next = pos_reg;
                len_next   = LEN_ONE;
                case (char_code)
                    ets_pkg::CH_BANG:   mode_next = ets_pkg::M_BANG;
                    ets_pkg::CH_BAR:    mode_next = ets_pkg::M_BAR;
                    ets_pkg::CH_AMP:    mode_next = ets_pkg::M_AMP;
                    ets_pkg::CH_EQ:     mode_next = ets_pkg::M_EQ;
                    ets_pkg::CH_LT:     mode_next = ets_pkg::M_LT;
                    ets_pkg::CH_GT:     mode_next = ets_pkg::M_GT;
                    ets_pkg::CH_DOLLAR: mode_next = ets_pkg::M_DOLLAR;
                    ets_pkg::CH_SQUOTE, ets_pkg::CH_DQUOTE:
                    begin
                        mode_next  = ets_pkg::M_STRING;
                        quote_next = char_code;
                    end
                    default:
                    begin
                        if (st != ets_pkg::TT_END)
                        begin
                            b.items[cnt] = ets_pkg::make_result(st, 16'(start_next),
                                16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                            cnt = cnt + 1'b1;
                        end
                        else if (ets_pkg::is_digit(char_code))
                        begin
                            mode_next = ets_pkg::M_NUM_INT;
                        end
                        else if (char_code == ets_pkg::CH_UNDER ||
                                 ets_pkg::is_alpha(char_code))
                        begin
                            mode_next = ets_pkg::M_IDENT;
                        end
                        else
                        begin
                            b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_END,
                                16'(start_next), 16'(LEN_ONE),
                                ets_pkg::ERR_UNEXPECTED, 1'b0);
                            cnt = cnt + 1'b1;
                            err_next = 1'b1;
                        end
                    end
                endcase
            end

            if (last_of_text && !err_next)
            begin
                case (mode_next)
                    ets_pkg::M_IDENT, ets_pkg::M_DOLLAR:
                    begin
                        b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_IDENT,
                            16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                        cnt = cnt + 1'b1;
                    end
                    ets_pkg::M_NUM_INT, ets_pkg::M_NUM_FRAC:
                    begin
                        b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_NUMBER,
                            16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                        cnt = cnt + 1'b1;
                    end
                    ets_pkg::M_STRING:
                    begin
                        b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_END,
                            16'(start_next), 16'(len_next), ets_pkg::ERR_OPEN_STR, 1'b0);
                        cnt = cnt + 1'b1;
                    end
                    ets_pkg::M_BANG, ets_pkg::M_BANG_EQ, ets_pkg::M_EQ_EQ,
                    ets_pkg::M_LT, ets_pkg::M_GT:
                    begin
                        case (mode_next)
                            ets_pkg::M_BANG:    st = ets_pkg::TT_NOT;
                            ets_pkg::M_BANG_EQ: st = ets_pkg::TT_NE;
                            ets_pkg::M_EQ_EQ:   st = ets_pkg::TT_EQ;
                            ets_pkg::M_LT:      st = ets_pkg::TT_LT;
                            default:            st = ets_pkg::TT_GT;
                        endcase
                        b.items[cnt] = ets_pkg::make_result(st,
                            16'(start_next), 16'(len_next), ets_pkg::ERR_NONE, 1'b0);
                        cnt = cnt + 1'b1;
                    end
                    ets_pkg::M_EQ, ets_pkg::M_BAR, ets_pkg::M_AMP:
                    begin
                        b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_END,
                            16'(start_next), 16'(LEN_ONE), ets_pkg::ERR_UNEXPECTED, 1'b0);
                        cnt = cnt + 1'b1;
                    end
                    default:
                    begin
                        cnt = cnt;
                    end
                endcase
                mode_next = ets_pkg::M_IDLE;
            end
        end

        if (last_of_text)
        begin
            b.items[cnt] = ets_pkg::make_result(ets_pkg::TT_END, 16'(pos_next),
                16'(0), ets_pkg::ERR_NONE, 1'b1);
            cnt = cnt + 1'b1;
            mode_next  = ets_pkg::M_IDLE;
            quote_next = '0;
            start_next = '0;
            len_next   = '0;
            pos_next   = '0;
            err_next   = 1'b0;
        end

        b.count = cnt;
        bundle  = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ets_pkg::M_IDLE;
            quote_reg <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
        end
    end

endmodule

### hw/rtl/ets_out.sv
// ----------------------------------------------------------------------------
// ets_out
// Result register: holds the bundle for one byte and hands its words out
// one per cycle while word_stall is low; frees itself for the next bundle on the last word.
// ----------------------------------------------------------------------------
module ets_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    output logic             load_ready,
    input  ets_pkg::bundle_t bundle,
    output logic             word_valid,
    input  logic             word_stall,
    output ets_pkg::result_t word
);

    logic [ets_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [ets_pkg::CNT_W-1:0] idx_reg, idx_next;
    ets_pkg::result_t [ets_pkg::MAX_RES-1:0] items_reg;

    logic pop;
    logic last_pop;

    assign word_valid = (cnt_reg != '0);
    assign word       = items_reg[idx_reg];
    assign pop        = word_valid && !word_stall;
    assign last_pop   = pop && (idx_reg == (cnt_reg - 1'b1));
    assign load_ready = (cnt_reg == '0) || last_pop;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load_valid && load_ready)
        begin
            cnt_next = bundle.count;
            idx_next = '0;
        end
        else if (last_pop)
        begin
            cnt_next = '0;
            idx_next = '0;
        end
        else if (pop)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            items_reg <= bundle.items;
        end
    end

endmodule

### hw/rtl/expression_token_scanner.sv
// ----------------------------------------------------------------------------
// expression_token_scanner
// The first token word of a byte is valid in the cycle after the byte is taken.
// Throughput: one byte per cycle while token_stall is low and a byte yields at most
//   one word; a byte with 2 or 3 words holds the result register until its last goes.
// Reset: rst_n clears the scan state to idle at offset 0 and empties the
//   result register; a text's final byte resets the scan state for the next text.
// ----------------------------------------------------------------------------
module expression_token_scanner #(
    parameter int POSITION_BITS = ets_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          char_valid,
    output logic                          char_stall,
    input  logic [7:0]                    char_code,
    input  logic                          last_of_text,
    output logic                          token_valid,
    input  logic                          token_stall,
    output logic [ets_pkg::TYPE_W-1:0]    token_type,
    output logic [ets_pkg::FIELD_W-1:0]   start_position,
    output logic [ets_pkg::FIELD_W-1:0]   token_length,
    output logic [ets_pkg::ERR_W-1:0]     error_code,
    output logic                          end_of_text
);

    ets_pkg::bundle_t bundle;
    ets_pkg::result_t word;
    logic             load_ready;
    logic             advance;

    assign char_stall = !load_ready;
    assign advance    = char_valid && load_ready;

    ets_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .char_code    (char_code),
        .last_of_text (last_of_text),
        .bundle       (bundle)
    );

    ets_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (char_valid),
        .load_ready (load_ready),
        .bundle     (bundle),
        .word_valid (token_valid),
        .word_stall (token_stall),
        .word       (word)
    );

    assign token_type     = word.token_type;
    assign start_position = word.start_position;
    assign token_length   = word.token_length;
    assign error_code     = word.error_code;
    assign end_of_text    = word.end_of_text;

endmodule
